// ----- hw/rtl/lru_page_replacement_defines.svh -----
// Assertion macros used by the checker file.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define LRUPR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru_page_replacement: same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define LRUPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru_page_replacement: next-cycle check failed");

`endif

// ----- hw/rtl/lrupr_pkg.sv -----
`timescale 1ns / 1ps

package lrupr_pkg;

   localparam int ACTIVE_W     = 5;
   localparam int ACTIVE_RESET = 16;
   localparam int FAULT_W      = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // register index, taken from paddr[2]
   localparam logic REG_ACTIVE_FRAMES = 1'b0;

   // flags that travel with the scan token down the cell chain
   typedef struct packed {
      logic tok;
      logic hit;
      logic empty;
      logic best;
   } scan_flags_type;

   // broadcast update of the recency ranks after a decision
   typedef struct packed {
      logic en;
      logic fvalid;
      logic load;
   } upd_ctl_type;

endpackage

// ----- hw/rtl/lrupr_cell.sv -----
`timescale 1ns / 1ps

module lrupr_cell #(
   parameter int PAGE_BITS = 16,
   parameter int IDX_W     = 4,
   parameter int INDEX     = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       active,
   input  lrupr_pkg::scan_flags_type  prev_flags,
   input  logic [PAGE_BITS-1:0]       prev_key,
   input  logic [IDX_W-1:0]           prev_slot,
   input  logic [IDX_W-1:0]           prev_rank,
   input  logic [PAGE_BITS-1:0]       prev_evp,
   output lrupr_pkg::scan_flags_type  next_flags,
   output logic [PAGE_BITS-1:0]       next_key,
   output logic [IDX_W-1:0]           next_slot,
   output logic [IDX_W-1:0]           next_rank,
   output logic [PAGE_BITS-1:0]       next_evp,
   input  lrupr_pkg::upd_ctl_type     upd,
   input  logic [IDX_W-1:0]           upd_slot,
   input  logic [IDX_W-1:0]           upd_rank,
   input  logic [PAGE_BITS-1:0]       upd_page
);
   import lrupr_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 valid_ff, valid_in;
   logic [IDX_W-1:0]     rank_ff, rank_in;

   scan_flags_type       flags_ff, flags_in;
   logic [PAGE_BITS-1:0] key_ff, key_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [IDX_W-1:0]     srank_ff, srank_in;
   logic [PAGE_BITS-1:0] evp_ff, evp_in;

   logic match;
   logic self;

   // scan: merge this frame into the token; hit beats empty beats victim
   always_comb begin
      match    = active && valid_ff && (page_ff == prev_key);
      flags_in = prev_flags;
      key_in   = prev_key;
      slot_in  = prev_slot;
      srank_in = prev_rank;
      evp_in   = prev_evp;
      if (prev_flags.tok && !prev_flags.hit) begin
         if (match) begin
            flags_in.hit = 1'b1;
            slot_in      = MY_IDX;
            srank_in     = rank_ff;
         end else if (active && !prev_flags.empty) begin
            if (!valid_ff) begin
               flags_in.empty = 1'b1;
               slot_in        = MY_IDX;
            end else if (!prev_flags.best || (rank_ff > prev_rank)) begin
               flags_in.best = 1'b1;
               slot_in       = MY_IDX;
               srank_in      = rank_ff;
               evp_in        = page_ff;
            end
         end
      end
   end

   // touch: chosen frame goes to rank 0, frames ahead of it age
   always_comb begin
      self     = (upd_slot == MY_IDX);
      page_in  = page_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (upd.en) begin
         if (self) begin
            valid_in = 1'b1;
            rank_in  = '0;
            if (upd.load) begin
               page_in = upd_page;
            end
         end else if (valid_ff && (!upd.fvalid || (rank_ff < upd_rank))) begin
            rank_in = rank_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         flags_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         flags_ff <= flags_in;
      end
      page_ff  <= page_in;
      key_ff   <= key_in;
      slot_ff  <= slot_in;
      srank_ff <= srank_in;
      evp_ff   <= evp_in;
   end

   assign next_flags = flags_ff;
   assign next_key   = key_ff;
   assign next_slot  = slot_ff;
   assign next_rank  = srank_ff;
   assign next_evp   = evp_ff;

endmodule

// ----- hw/rtl/lrupr_ctrl.sv -----
`timescale 1ns / 1ps

module lrupr_ctrl #(
   parameter int PAGE_BITS = 16,
   parameter int IDX_W     = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   output logic                              accept,
   input  lrupr_pkg::scan_flags_type         exit_flags,
   input  logic [PAGE_BITS-1:0]              exit_key,
   input  logic [IDX_W-1:0]                  exit_slot,
   input  logic [IDX_W-1:0]                  exit_rank,
   input  logic [PAGE_BITS-1:0]              exit_evp,
   output lrupr_pkg::upd_ctl_type            upd,
   output logic [IDX_W-1:0]                  upd_slot,
   output logic [IDX_W-1:0]                  upd_rank,
   output logic [PAGE_BITS-1:0]              upd_page,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic [IDX_W-1:0]                  rsp_slot,
   output logic                              rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]              rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_W-1:0]     rsp_fault_count
);
   import lrupr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_DECIDE = 3'b100
   } ctrl_state_type;

   ctrl_state_type       state_ff, state_in;

   scan_flags_type       dec_flags_ff;
   logic [PAGE_BITS-1:0] dec_key_ff;
   logic [IDX_W-1:0]     dec_slot_ff;
   logic [IDX_W-1:0]     dec_rank_ff;
   logic [PAGE_BITS-1:0] dec_evp_ff;

   logic [FAULT_W-1:0]   fault_ff, fault_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff;
   logic [IDX_W-1:0]     rsp_slot_ff;
   logic                 rsp_ev_ff;
   logic [PAGE_BITS-1:0] rsp_evp_ff;
   logic [FAULT_W-1:0]   rsp_fault_ff;

   logic                 dec_load;
   logic                 commit;
   logic                 dec_ev;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign dec_load  = (state_ff == ST_SCAN) && exit_flags.tok;
   assign commit    = (state_ff == ST_DECIDE) && (!rsp_valid_ff || !rsp_stall);
   // no hit and no empty frame: the victim was replaced
   assign dec_ev    = !dec_flags_ff.hit && !dec_flags_ff.empty;

   assign upd.en     = commit;
   assign upd.fvalid = dec_flags_ff.hit || dec_ev;
   assign upd.load   = !dec_flags_ff.hit;
   assign upd_slot   = dec_slot_ff;
   assign upd_rank   = dec_rank_ff;
   assign upd_page   = dec_key_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (exit_flags.tok) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      fault_in = fault_ff;
      if (commit && !dec_flags_ff.hit && (fault_ff != '1)) begin
         fault_in = fault_ff + FAULT_W'(1);
      end
   end

   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (dec_load) begin
         dec_flags_ff <= exit_flags;
         dec_key_ff   <= exit_key;
         dec_slot_ff  <= exit_slot;
         dec_rank_ff  <= exit_rank;
         dec_evp_ff   <= exit_evp;
      end
      if (commit) begin
         rsp_hit_ff   <= dec_flags_ff.hit;
         rsp_slot_ff  <= dec_slot_ff;
         rsp_ev_ff    <= dec_ev;
         rsp_evp_ff   <= dec_ev ? dec_evp_ff : '0;
         rsp_fault_ff <= fault_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_page  = rsp_evp_ff;
   assign rsp_fault_count   = rsp_fault_ff;

endmodule

// ----- hw/rtl/lru_page_replacement.sv -----
`timescale 1ns / 1ps

// LRU page replacement over MAX_FRAMES fully associative frames, one frame
// per cell in a chain. Each accepted page reference sends a token down the
// chain one cell per cycle; each cell folds in its own hit, empty-frame or
// oldest-frame candidate. When the token leaves the last cell the decision
// is latched, the result is loaded and all cells update their recency rank
// in parallel. The token passes the cell registers, then the decision
// register; the result register is loaded once it is free. A new item is
// accepted only after the last one's result is loaded: one item in flight.
// The result register lets a finished result wait on rsp_stall while the
// next item is already accepted. Reset empties every frame. Register 0
// (address 0) holds active_frames; 0 acts as 1 and values above
// MAX_FRAMES act as MAX_FRAMES. Frames above the count keep their contents.
module lru_page_replacement #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [PAGE_BITS-1:0]                  req_page,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] rsp_slot,
   output logic                                  rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]                  rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_W-1:0]         rsp_fault_count,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [lrupr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lrupr_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lrupr_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);
   import lrupr_pkg::*;

   localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FCNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int CNT_W   = (FCNT_W > ACTIVE_W) ? FCNT_W : ACTIVE_W;

   logic [ACTIVE_W-1:0]  active_ff, active_in;
   logic [CNT_W-1:0]     n_eff;
   logic                 csr_wr;

   logic                 accept;
   upd_ctl_type          upd;
   logic [IDX_W-1:0]     upd_slot;
   logic [IDX_W-1:0]     upd_rank;
   logic [PAGE_BITS-1:0] upd_page;

   scan_flags_type       c_flags [MAX_FRAMES+1];
   logic [PAGE_BITS-1:0] c_key   [MAX_FRAMES+1];
   logic [IDX_W-1:0]     c_slot  [MAX_FRAMES+1];
   logic [IDX_W-1:0]     c_rank  [MAX_FRAMES+1];
   logic [PAGE_BITS-1:0] c_evp   [MAX_FRAMES+1];
   logic [MAX_FRAMES-1:0] act;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_ACTIVE_FRAMES);
   assign active_in  = csr_wr ? csr_pwdata[ACTIVE_W-1:0] : active_ff;
   assign csr_prdata = (csr_paddr[2] == REG_ACTIVE_FRAMES)
                       ? CSR_DATA_W'(active_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_W'(ACTIVE_RESET);
      end else begin
         active_ff <= active_in;
      end
   end

   always_comb begin
      n_eff = CNT_W'(active_ff);
      if (active_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (CNT_W'(active_ff) > CNT_W'(MAX_FRAMES)) begin
         n_eff = CNT_W'(MAX_FRAMES);
      end
   end

   // token entry
   always_comb begin
      c_flags[0]     = '0;
      c_flags[0].tok = accept;
      c_key[0]       = req_page;
      c_slot[0]      = '0;
      c_rank[0]      = '0;
      c_evp[0]       = '0;
   end

   for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
      assign act[g] = (CNT_W'(g) < n_eff);

      lrupr_cell #(
         .PAGE_BITS (PAGE_BITS),
         .IDX_W     (IDX_W),
         .INDEX     (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .active     (act[g]),
         .prev_flags (c_flags[g]),
         .prev_key   (c_key[g]),
         .prev_slot  (c_slot[g]),
         .prev_rank  (c_rank[g]),
         .prev_evp   (c_evp[g]),
         .next_flags (c_flags[g+1]),
         .next_key   (c_key[g+1]),
         .next_slot  (c_slot[g+1]),
         .next_rank  (c_rank[g+1]),
         .next_evp   (c_evp[g+1]),
         .upd        (upd),
         .upd_slot   (upd_slot),
         .upd_rank   (upd_rank),
         .upd_page   (upd_page)
      );
   end

   lrupr_ctrl #(
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IDX_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .accept            (accept),
      .exit_flags        (c_flags[MAX_FRAMES]),
      .exit_key          (c_key[MAX_FRAMES]),
      .exit_slot         (c_slot[MAX_FRAMES]),
      .exit_rank         (c_rank[MAX_FRAMES]),
      .exit_evp          (c_evp[MAX_FRAMES]),
      .upd               (upd),
      .upd_slot          (upd_slot),
      .upd_rank          (upd_rank),
      .upd_page          (upd_page),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_slot          (rsp_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count)
   );

endmodule

// ----- hw/rtl/lrupr_check.sv -----
`timescale 1ns / 1ps
`include "lru_page_replacement_defines.svh"

module lrupr_check #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_hit,
   input logic                                  rsp_evicted_valid,
   input logic [PAGE_BITS-1:0]                  rsp_evicted_page,
   input logic [lrupr_pkg::FAULT_W-1:0]         rsp_fault_count
);

   // a hit never replaces a page
   `LRUPR_ASSERT_IMP(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted_valid)

   // no eviction reports page zero
   `LRUPR_ASSERT_IMP(a_evp_zero, clock, reset, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0)

   // one item in flight: an accepted item blocks the next cycle's input
   `LRUPR_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall)

   `LRUPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fault_count))

endmodule

bind lru_page_replacement lrupr_check #(
   .MAX_FRAMES (MAX_FRAMES),
   .PAGE_BITS  (PAGE_BITS)
) u_lrupr_check (.*);
